// ----- rtl/core/ltm_pkg.sv -----
`default_nettype none
package ltm_pkg;

	localparam int unsigned ID_W    = 16;
	localparam int unsigned LOCK_W  = 64;
	localparam int unsigned COUNT_W = 32;

	typedef enum logic [1:0] {
		MODE_STAT    = 2'd0,
		MODE_ACQUIRE = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_LOCK    = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_QUEUE_FULL = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ANSWER = 1'b0,
		KIND_GRANT  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_MISS,
		FSM_GRANT
	} fsm_t;

endpackage
`default_nettype wire

// ----- rtl/core/ltm_ram.sv -----
`default_nettype none
module ltm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/lock_table_manager_top.sv -----
`default_nettype none
// Channel   Handshake            Words
// request   start / busy         mode, client_id, lock_id
// result    result_valid strobe  result_kind, dest_client, result_lock, status,
//                                acquire_count, last
//
// A request word is taken when start is high and busy is low.
// A hit or a miss is found by a tag search that reads the tag memory one entry a
// cycle over the entries allocated so far; a word of the unused mode is taken
// without making the block busy.
// A release that hands the lock to a waiter sends the grant from a further state.
// Reset clears the allocation count and control state; no clearing pass runs.
// Results show for one cycle on result_valid; the receiver cannot stall.
module lock_table_manager_top #(
	parameter int unsigned TABLE_ENTRIES    = 64,
	parameter int unsigned WAITERS_PER_LOCK = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] client_id,
	input  wire logic [63:0] lock_id,
	output logic             result_valid,
	output logic             result_kind,
	output logic [15:0]      dest_client,
	output logic [63:0]      result_lock,
	output logic [1:0]       status,
	output logic [31:0]      acquire_count,
	output logic             last
);

	localparam int unsigned EW  = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned HW  = (WAITERS_PER_LOCK > 1) ? $clog2(WAITERS_PER_LOCK) : 1;
	localparam int unsigned FW  = $clog2(WAITERS_PER_LOCK + 1);
	localparam int unsigned WD  = TABLE_ENTRIES * WAITERS_PER_LOCK;
	localparam int unsigned WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam int unsigned SW  = FW + 1;
	// entry word: held, count, queue head, queue fill
	localparam int unsigned ENT_W = 1 + ltm_pkg::COUNT_W + HW + FW;
	localparam logic [CW-1:0] TABLE_CAP = CW'(TABLE_ENTRIES);
	localparam logic [SW-1:0] WAIT_CAP  = SW'(WAITERS_PER_LOCK);

	ltm_pkg::fsm_t state_q, state_d;

	logic [1:0]                  mode_q;
	logic [ltm_pkg::ID_W-1:0]    client_q;
	logic [ltm_pkg::LOCK_W-1:0]  lock_q;
	logic [CW-1:0]               alloc_q;
	logic [CW-1:0]               scan_q;
	logic                        pend_s1;
	logic [EW-1:0]               addr_s1;
	logic [EW-1:0]               eidx_q;

	logic                        tag_we;
	logic [EW-1:0]               tag_waddr, tag_raddr;
	logic [ltm_pkg::LOCK_W-1:0]  tag_rdata;
	logic                        ent_we;
	logic [EW-1:0]               ent_waddr, ent_raddr;
	logic [ENT_W-1:0]            ent_wdata, ent_rdata;
	logic                        wt_we;
	logic [WAW-1:0]              wt_waddr, wt_raddr;
	logic [ltm_pkg::ID_W-1:0]    wt_rdata;

	logic                        hit;
	logic                        scan_end;
	logic                        ent_held;
	logic [ltm_pkg::COUNT_W-1:0] ent_count, count_inc;
	logic [HW-1:0]               ent_head, head_next, slot;
	logic [FW-1:0]               ent_fill;
	logic [SW-1:0]               slot_sum;
	logic [WAW-1:0]              wt_base;
	logic                        can_handoff;

	logic                        res_v;
	logic                        res_kind;
	logic [ltm_pkg::ID_W-1:0]    res_client;
	logic [1:0]                  res_status;
	logic [ltm_pkg::COUNT_W-1:0] res_count;
	logic                        res_last;

	logic                        out_v_q, out_kind_q, out_last_q;
	logic [ltm_pkg::ID_W-1:0]    out_client_q;
	logic [1:0]                  out_status_q;
	logic [ltm_pkg::COUNT_W-1:0] out_count_q;

	ltm_ram #(.WIDTH(ltm_pkg::LOCK_W), .DEPTH(TABLE_ENTRIES), .AW(EW)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(lock_q),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);

	ltm_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES), .AW(EW)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata)
	);

	ltm_ram #(.WIDTH(ltm_pkg::ID_W), .DEPTH(WD), .AW(WAW)) u_wait (
		.clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(client_q),
		.raddr(wt_raddr), .rdata(wt_rdata)
	);

	// entry word fields, valid in DECIDE
	assign {ent_held, ent_count, ent_head, ent_fill} = ent_rdata;
	assign count_inc = (ent_count == '1) ? ent_count : ent_count + 1'b1;
	assign slot_sum  = SW'(ent_head) + SW'(ent_fill);
	assign slot      = (slot_sum >= WAIT_CAP) ? HW'(slot_sum - WAIT_CAP) : HW'(slot_sum);
	assign head_next = (SW'(ent_head) + 1'b1 >= WAIT_CAP) ? '0 : HW'(SW'(ent_head) + 1'b1);
	assign wt_base   = WAW'(eidx_q) * WAW'(WAITERS_PER_LOCK);
	assign can_handoff = ent_held && (ent_fill != '0);

	// tag compare on the word read last cycle
	assign hit      = pend_s1 && (tag_rdata == lock_q);
	assign scan_end = !pend_s1 && (scan_q == alloc_q);

	assign busy = (state_q != ltm_pkg::FSM_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ltm_pkg::FSM_IDLE: begin
				if (start && mode != ltm_pkg::MODE_NONE) state_d = ltm_pkg::FSM_SCAN;
			end
			ltm_pkg::FSM_SCAN: begin
				if (hit) state_d = ltm_pkg::FSM_DECIDE;
				else if (scan_end) state_d = ltm_pkg::FSM_MISS;
			end
			ltm_pkg::FSM_DECIDE: begin
				if (mode_q == ltm_pkg::MODE_RELEASE && can_handoff)
					state_d = ltm_pkg::FSM_GRANT;
				else
					state_d = ltm_pkg::FSM_IDLE;
			end
			ltm_pkg::FSM_MISS:  state_d = ltm_pkg::FSM_IDLE;
			ltm_pkg::FSM_GRANT: state_d = ltm_pkg::FSM_IDLE;
			default:            state_d = ltm_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		tag_we     = 1'b0;
		tag_waddr  = alloc_q[EW-1:0];
		tag_raddr  = scan_q[EW-1:0];
		ent_we     = 1'b0;
		ent_waddr  = eidx_q;
		ent_wdata  = ent_rdata;
		ent_raddr  = addr_s1;
		wt_we      = 1'b0;
		wt_waddr   = wt_base + WAW'(slot);
		wt_raddr   = wt_base + WAW'(ent_head);
		res_v      = 1'b0;
		res_kind   = ltm_pkg::KIND_ANSWER;
		res_client = client_q;
		res_status = ltm_pkg::ST_OK;
		res_count  = '0;
		res_last   = 1'b1;
		case (state_q)
			ltm_pkg::FSM_DECIDE: begin
				case (mode_q)
					ltm_pkg::MODE_STAT: begin
						res_v     = 1'b1;
						res_count = ent_count;
					end
					ltm_pkg::MODE_ACQUIRE: begin
						if (!ent_held) begin
							ent_we    = 1'b1;
							ent_wdata = {1'b1, count_inc, ent_head, ent_fill};
							res_v     = 1'b1;
						end else if (SW'(ent_fill) >= WAIT_CAP) begin
							res_v      = 1'b1;
							res_status = ltm_pkg::ST_QUEUE_FULL;
						end else begin
							// queue the client, answer comes with a later release
							wt_we     = 1'b1;
							ent_we    = 1'b1;
							ent_wdata = {1'b1, ent_count, ent_head, FW'(ent_fill + 1'b1)};
						end
					end
					ltm_pkg::MODE_RELEASE: begin
						ent_we = 1'b1;
						res_v  = 1'b1;
						if (can_handoff) begin
							ent_wdata = {1'b1, count_inc, head_next, FW'(ent_fill - 1'b1)};
							res_last  = 1'b0;
						end else begin
							ent_wdata = {1'b0, ent_count, ent_head, ent_fill};
						end
					end
					default: ;
				endcase
			end
			ltm_pkg::FSM_MISS: begin
				res_v = 1'b1;
				if (mode_q == ltm_pkg::MODE_ACQUIRE) begin
					if (alloc_q == TABLE_CAP) begin
						res_status = ltm_pkg::ST_TABLE_FULL;
					end else begin
						tag_we    = 1'b1;
						ent_we    = 1'b1;
						ent_waddr = alloc_q[EW-1:0];
						ent_wdata = {1'b1, ltm_pkg::COUNT_W'(1), {HW{1'b0}}, {FW{1'b0}}};
					end
				end else begin
					res_status = ltm_pkg::ST_NO_LOCK;
				end
			end
			ltm_pkg::FSM_GRANT: begin
				res_v      = 1'b1;
				res_kind   = ltm_pkg::KIND_GRANT;
				res_client = wt_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ltm_pkg::FSM_IDLE;
			alloc_q <= '0;
			scan_q  <= '0;
			pend_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_v_q <= res_v;
			if (tag_we) alloc_q <= alloc_q + 1'b1;
			// walk the allocated entries, one tag read a cycle
			if (state_q == ltm_pkg::FSM_SCAN && scan_q != alloc_q) begin
				scan_q  <= scan_q + 1'b1;
				pend_s1 <= 1'b1;
			end else begin
				if (state_q != ltm_pkg::FSM_SCAN) scan_q <= '0;
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ltm_pkg::FSM_IDLE && start) begin
			mode_q   <= mode;
			client_q <= client_id;
			lock_q   <= lock_id;
		end
		addr_s1 <= scan_q[EW-1:0];
		if (hit) eidx_q <= addr_s1;
		out_kind_q   <= res_kind;
		out_client_q <= res_client;
		out_status_q <= res_status;
		out_count_q  <= res_count;
		out_last_q   <= res_last;
	end

	assign result_valid  = out_v_q;
	assign result_kind   = out_kind_q;
	assign dest_client   = out_client_q;
	assign result_lock   = lock_q;
	assign status        = out_status_q;
	assign acquire_count = out_count_q;
	assign last          = out_last_q;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;

	localparam int TABLE_SIZE = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int STALL_LIMIT = 20000;

	// Each row is one request word; chk_exp marks rows whose answer is typed in.
	typedef struct {
		ltm_pkg::mode_t   op;
		logic [15:0]      cid;
		logic [63:0]      lid;
		bit               chk_exp;
		ltm_pkg::status_t exp_st;
		logic [31:0]      exp_cnt;
	} req_row_t;

	typedef struct {
		ltm_pkg::kind_t   kind;
		logic [15:0]      dest;
		logic [63:0]      lid;
		ltm_pkg::status_t st;
		logic [31:0]      cnt;
		logic             fin;
	} lock_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] mode = ltm_pkg::MODE_STAT;
	logic [15:0] client_id = '0;
	logic [63:0] lock_id = '0;
	wire busy, result_valid, result_kind, last;
	wire [15:0] dest_client;
	wire [63:0] result_lock;
	wire [1:0] status;
	wire [31:0] acquire_count;

	lock_table_manager_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .client_id(client_id), .lock_id(lock_id),
		.result_valid(result_valid), .result_kind(result_kind),
		.dest_client(dest_client), .result_lock(result_lock),
		.status(status), .acquire_count(acquire_count), .last(last)
	);

	always #5 clk = ~clk;

	// Shadow copy of the lock table.
	bit          tbl_valid [TABLE_SIZE];
	logic [63:0] tbl_tag [TABLE_SIZE];
	bit          tbl_held [TABLE_SIZE];
	logic [31:0] tbl_count [TABLE_SIZE];
	logic [15:0] tbl_waiters [TABLE_SIZE][$];

	lock_reply_t pending_replies[$];
	bit failed = 1'b0;
	int idle_cycles = 0;
	logic [63:0] known_locks[$];

	function automatic int lookup_lock(logic [63:0] lid);
		for (int i = 0; i < TABLE_SIZE; i++)
			if (tbl_valid[i] && tbl_tag[i] == lid) return i;
		return -1;
	endfunction

	// Apply one request to the shadow table and queue the replies it causes.
	function automatic void predict_request(ltm_pkg::mode_t op, logic [15:0] cid,
			logic [63:0] lid);
		int e;
		lock_reply_t r;
		e = lookup_lock(lid);
		r = '{ltm_pkg::KIND_ANSWER, cid, lid, ltm_pkg::ST_OK, 32'd0, 1'b1};
		case (op)
			ltm_pkg::MODE_STAT: begin
				if (e < 0) r.st = ltm_pkg::ST_NO_LOCK;
				else r.cnt = tbl_count[e];
				pending_replies.push_back(r);
			end
			ltm_pkg::MODE_ACQUIRE: begin
				if (e < 0) begin
					for (int i = 0; i < TABLE_SIZE; i++)
						if (!tbl_valid[i]) begin
							e = i;
							break;
						end
					if (e < 0) r.st = ltm_pkg::ST_TABLE_FULL;
					else begin
						tbl_valid[e] = 1;
						tbl_tag[e] = lid;
						tbl_held[e] = 1;
						tbl_count[e] = 1;
						tbl_waiters[e].delete();
						known_locks.push_back(lid);
					end
					pending_replies.push_back(r);
				end else if (!tbl_held[e]) begin
					tbl_held[e] = 1;
					if (tbl_count[e] != '1) tbl_count[e]++;
					pending_replies.push_back(r);
				end else if (tbl_waiters[e].size() >= QUEUE_DEPTH) begin
					r.st = ltm_pkg::ST_QUEUE_FULL;
					pending_replies.push_back(r);
				end else
					tbl_waiters[e].push_back(cid);
			end
			ltm_pkg::MODE_RELEASE: begin
				if (e < 0) begin
					r.st = ltm_pkg::ST_NO_LOCK;
					pending_replies.push_back(r);
				end else if (tbl_held[e] && tbl_waiters[e].size() > 0) begin
					r.fin = 1'b0;
					pending_replies.push_back(r);
					r = '{ltm_pkg::KIND_GRANT, tbl_waiters[e].pop_front(), lid,
						ltm_pkg::ST_OK, 32'd0, 1'b1};
					if (tbl_count[e] != '1) tbl_count[e]++;
					pending_replies.push_back(r);
				end else begin
					tbl_held[e] = 0;
					pending_replies.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		lock_reply_t x;
		if (result_valid) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result lock %h client %h", $time,
					result_lock, dest_client);
				failed = 1'b1;
			end else begin
				x = pending_replies.pop_front();
				if (result_kind !== x.kind || dest_client !== x.dest ||
						result_lock !== x.lid || status !== x.st ||
						acquire_count !== x.cnt || last !== x.fin) begin
					$display("%0t: expected kind %0d client %h lock %h st %0d cnt %0d last %0d",
						$time, x.kind, x.dest, x.lid, x.st, x.cnt, x.fin);
					$display("%0t: actual   kind %0d client %h lock %h st %0d cnt %0d last %0d",
						$time, result_kind, dest_client, result_lock, status,
						acquire_count, last);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: count cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	bit check_row;
	ltm_pkg::status_t row_st;
	logic [31:0] row_cnt;
	int burst_left = 0;
	bit allow_idle = 1'b1;

	// Present one word, hold it until taken, then drop start.
	task automatic send_word(ltm_pkg::mode_t op, logic [15:0] cid, logic [63:0] lid);
		if (allow_idle && burst_left == 0 && $urandom_range(0, 5) == 0)
			burst_left = $urandom_range(1, 16);
		while (burst_left > 0) begin
			@(negedge clk);
			start <= 1'b0;
			burst_left--;
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= op;
		client_id <= cid;
		lock_id <= lid;
		do @(posedge clk); while (busy);
		if (check_row) begin
			predict_request(op, cid, lid);
			if (pending_replies.size() > 0 &&
					(pending_replies[$].st != row_st || pending_replies[$].cnt != row_cnt)) begin
				$display("%0t: table row expected st %0d cnt %0d, predicted st %0d cnt %0d",
					$time, row_st, row_cnt, pending_replies[$].st, pending_replies[$].cnt);
				failed = 1'b1;
			end
		end else
			predict_request(op, cid, lid);
		@(negedge clk);
		start <= 1'b0;
	endtask

	req_row_t directed[$];
	logic [63:0] pick;
	int op_sel;
	ltm_pkg::mode_t op_rnd;

	initial begin
		directed = '{
			'{ltm_pkg::MODE_STAT,    16'h0000, 64'h0, 1, ltm_pkg::ST_NO_LOCK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1,
				ltm_pkg::ST_NO_LOCK, 32'd0},
			'{ltm_pkg::MODE_ACQUIRE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_STAT,    16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 1,
				ltm_pkg::ST_OK, 32'd1},
			'{ltm_pkg::MODE_ACQUIRE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_ACQUIRE, 16'h0002, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_ACQUIRE, 16'h0003, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_ACQUIRE, 16'h0004, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_ACQUIRE, 16'h0005, 64'hFFFF_FFFF_FFFF_FFFF, 1,
				ltm_pkg::ST_QUEUE_FULL, 32'd0},
			'{ltm_pkg::MODE_NONE,    16'hAAAA, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h1234, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h0002, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h0003, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h0004, 64'hFFFF_FFFF_FFFF_FFFF, 0,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h0004, 64'hFFFF_FFFF_FFFF_FFFF, 1,
				ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_STAT,    16'h5555, 64'hFFFF_FFFF_FFFF_FFFF, 1,
				ltm_pkg::ST_OK, 32'd5},
			'{ltm_pkg::MODE_ACQUIRE, 16'h0000, 64'h0, 1, ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_RELEASE, 16'h0000, 64'h0, 0, ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_ACQUIRE, 16'h7777, 64'h0, 0, ltm_pkg::ST_OK, 32'd0},
			'{ltm_pkg::MODE_STAT,    16'h0000, 64'h0, 1, ltm_pkg::ST_OK, 32'd2}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			check_row = directed[i].chk_exp;
			row_st = directed[i].exp_st;
			row_cnt = directed[i].exp_cnt;
			send_word(directed[i].op, directed[i].cid, directed[i].lid);
		end
		check_row = 1'b0;

		// Random traffic: mostly reuse locks already in the table so queues fill and
		// hand off; fresh ids fill the table until it reports full.
		for (int n = 0; n < 1700; n++) begin
			if (n > 1500) allow_idle = 1'b0;
			op_sel = $urandom_range(0, 19);
			op_rnd = op_sel < 4 ? ltm_pkg::MODE_STAT : op_sel < 11 ? ltm_pkg::MODE_ACQUIRE :
				op_sel < 19 ? ltm_pkg::MODE_RELEASE : ltm_pkg::MODE_NONE;
			if (known_locks.size() > 0 && $urandom_range(0, 9) < 8)
				pick = known_locks[$urandom_range(0, known_locks.size() - 1)];
			else
				pick = {$urandom, $urandom};
			send_word(op_rnd, 16'($urandom), pick);
		end

		while (pending_replies.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
